@@ hdl/rfpd_pkg.sv @@
package rfpd_pkg;

   localparam int CFG_W = 9;
   localparam int CMD_W = 3;
   localparam int DATA_W = 32;
   localparam int AMOUNT_W = 8;
   localparam int FILL_W = 8;

   localparam int DEF_MAX_SLOTS = 256;
   localparam int DEF_ELEMENT_WIDTH = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH       = 3'd0,
      CMD_FORCE_PUSH = 3'd1,
      CMD_POP        = 3'd2,
      CMD_PEEK       = 3'd3,
      CMD_DROP       = 3'd4,
      CMD_CLEAR      = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [DATA_W-1:0]   write_data;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [DATA_W-1:0] read_data;
      logic [FILL_W-1:0] fill_count;
   } rsp_type;

   // response bookkeeping that travels beside the memory read
   typedef struct packed {
      logic              valid;
      logic              status;
      logic              read_sel;
      logic [FILL_W-1:0] fill;
   } meta_type;

endpackage

@@ hdl/ring_fifo_with_peek_drop.sv @@
// Circular FIFO with push, force push, pop, peek, drop and clear commands.
// One command is accepted per clock when start is high and busy is low; busy
// is high only while a csr write is offered, since csr writes take priority.
// Every accepted command gives exactly one response word, with rsp_strobe
// high for one cycle, on the cycle after acceptance, when the registered read
// output of the slot memory holds the word. The receiver cannot stall, so
// it must take each response word when strobed. A csr write sets the ring
// length (zero counts as one, values above the slot memory are clamped) and
// empties the FIFO. One slot always stays free, so the FIFO holds at most
// ring length minus one words; read_data is zero for anything but a
// successful pop or peek.
module ring_fifo_with_peek_drop #(
   parameter int MAX_SLOTS = rfpd_pkg::DEF_MAX_SLOTS,
   parameter int ELEMENT_WIDTH = rfpd_pkg::DEF_ELEMENT_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  rfpd_pkg::req_type          req_word,
   output logic                       rsp_strobe,
   output rfpd_pkg::rsp_type          rsp_word,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rfpd_pkg::CFG_W-1:0] csr_data
);
   import rfpd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_SLOTS);

   logic                     mem_we;
   logic                     mem_re;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [ADDR_W-1:0]        mem_raddr;
   logic [ELEMENT_WIDTH-1:0] mem_q;
   meta_type                 meta;

   rfpd_ctrl #(
      .MAX_SLOTS(MAX_SLOTS),
      .ADDR_W(ADDR_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req(req_word),
      .busy(busy),
      .csr_valid(csr_valid),
      .csr_data(csr_data),
      .csr_ready(csr_ready),
      .mem_we(mem_we),
      .mem_waddr(mem_waddr),
      .mem_re(mem_re),
      .mem_raddr(mem_raddr),
      .meta(meta)
   );

   rfpd_ram #(
      .DEPTH(MAX_SLOTS),
      .WIDTH(ELEMENT_WIDTH),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(ELEMENT_WIDTH'(req_word.write_data)),
      .re(mem_re),
      .raddr(mem_raddr),
      .rdata(mem_q)
   );

   always_comb begin
      rsp_word            = '0;
      rsp_word.status     = meta.status;
      rsp_word.read_data  = meta.read_sel ? DATA_W'(mem_q) : '0;
      rsp_word.fill_count = meta.fill;
   end

   assign rsp_strobe = meta.valid;

endmodule

@@ hdl/rfpd_ram.sv @@
module rfpd_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/rfpd_ctrl.sv @@
module rfpd_ctrl #(
   parameter int MAX_SLOTS = 256,
   parameter int ADDR_W = $clog2(MAX_SLOTS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  rfpd_pkg::req_type         req,
   output logic                      busy,
   input  logic                      csr_valid,
   input  logic [rfpd_pkg::CFG_W-1:0] csr_data,
   output logic                      csr_ready,
   output logic                      mem_we,
   output logic [ADDR_W-1:0]         mem_waddr,
   output logic                      mem_re,
   output logic [ADDR_W-1:0]         mem_raddr,
   output rfpd_pkg::meta_type        meta
);
   import rfpd_pkg::*;

   localparam int RING_MAX = (MAX_SLOTS < 511) ? MAX_SLOTS : 511;
   localparam int RING_RESET = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
   localparam int PTR_W = $clog2(RING_MAX);
   localparam int SUM_W = ((PTR_W > AMOUNT_W) ? PTR_W : AMOUNT_W) + 1;

   logic [CFG_W-1:0] len_ff, len_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   meta_type         meta_ff, meta_in;

   logic             go;
   logic             csr_fire;
   logic [SUM_W-1:0] fill;
   logic [SUM_W-1:0] fill_after;
   logic [SUM_W-1:0] amount_ext;
   logic [PTR_W-1:0] next_tail;
   logic [PTR_W-1:0] peek_ptr;
   logic             full;
   logic             status;
   logic             read_hit;

   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [SUM_W-1:0] off,
                                                 input logic [CFG_W-1:0] len);
      logic [SUM_W-1:0] s;
      s = SUM_W'(ptr) + off;
      if (s >= SUM_W'(len)) begin
         s = s - SUM_W'(len);
      end
      return PTR_W'(s);
   endfunction

   function automatic logic [SUM_W-1:0] level(input logic [PTR_W-1:0] h,
                                              input logic [PTR_W-1:0] t,
                                              input logic [CFG_W-1:0] len);
      if (t >= h) begin
         return SUM_W'(t) - SUM_W'(h);
      end
      return SUM_W'(t) + SUM_W'(len) - SUM_W'(h);
   endfunction

   assign busy      = csr_valid;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign go        = start & ~busy;

   assign amount_ext = SUM_W'(req.amount);
   assign fill       = level(head_ff, tail_ff, len_ff);
   assign next_tail  = ring_add(tail_ff, SUM_W'(1), len_ff);
   assign full       = (next_tail == head_ff);
   // pop reads at the head, peek at head plus offset
   assign peek_ptr   = ring_add(head_ff,
                                (req.command == CMD_PEEK) ? amount_ext : '0, len_ff);

   always_comb begin
      len_in   = len_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      status   = 1'b0;
      read_hit = 1'b0;
      mem_we   = 1'b0;

      if (csr_fire) begin
         if (csr_data == '0) begin
            len_in = CFG_W'(1);
         end else if (csr_data > CFG_W'(RING_MAX)) begin
            len_in = CFG_W'(RING_MAX);
         end else begin
            len_in = csr_data;
         end
         head_in = '0;
         tail_in = '0;
      end else if (go) begin
         case (req.command)
            CMD_PUSH: begin
               if (!full) begin
                  mem_we  = 1'b1;
                  tail_in = next_tail;
               end else begin
                  status = 1'b1;
               end
            end
            CMD_FORCE_PUSH: begin
               mem_we  = 1'b1;
               tail_in = next_tail;
               if (full) begin
                  head_in = ring_add(head_ff, SUM_W'(1), len_ff);
               end
            end
            CMD_POP: begin
               if (fill != '0) begin
                  read_hit = 1'b1;
                  head_in  = ring_add(head_ff, SUM_W'(1), len_ff);
               end else begin
                  status = 1'b1;
               end
            end
            CMD_PEEK: begin
               if (amount_ext < fill) begin
                  read_hit = 1'b1;
               end else begin
                  status = 1'b1;
               end
            end
            CMD_DROP: begin
               if (amount_ext != '0 && amount_ext <= fill) begin
                  head_in = ring_add(head_ff, amount_ext, len_ff);
               end else begin
                  status = 1'b1;
               end
            end
            CMD_CLEAR: begin
               head_in = '0;
               tail_in = '0;
            end
            default: begin
               status = 1'b1;
            end
         endcase
      end
   end

   assign fill_after = level(head_in, tail_in, len_ff);

   always_comb begin
      meta_in          = '0;
      meta_in.valid    = go;
      meta_in.status   = status;
      meta_in.read_sel = read_hit;
      meta_in.fill     = FILL_W'(fill_after);
   end

   assign mem_re    = read_hit;
   assign mem_raddr = ADDR_W'(peek_ptr);
   assign mem_waddr = ADDR_W'(tail_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= CFG_W'(RING_RESET);
         head_ff <= '0;
         tail_ff <= '0;
         meta_ff <= '0;
      end else begin
         len_ff  <= len_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         meta_ff <= meta_in;
      end
   end

   assign meta = meta_ff;

   a_one_rsp_per_cmd: assert property (@(posedge clock) disable iff (reset)
      go |=> meta_ff.valid)
      else $error("accepted command gave no response");

   a_no_stray_rsp: assert property (@(posedge clock) disable iff (reset)
      !go |=> !meta_ff.valid)
      else $error("response without a command");

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(head_ff) < SUM_W'(len_ff) && SUM_W'(tail_ff) < SUM_W'(len_ff))
      else $error("pointer outside ring");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("memory read and write in one cycle");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      go && req.command == CMD_CLEAR |=> meta_ff.fill == '0 && !meta_ff.status)
      else $error("clear left words behind");

endmodule
